### hdl/utf8_validate_and_count_core_defines.svh
// Assertion macros shared by the UTF-8 validator RTL.
`ifndef UTF8_VALIDATE_AND_COUNT_CORE_DEFINES_SVH
`define UTF8_VALIDATE_AND_COUNT_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and switched off during reset.
`define UVC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and switched off during reset.
`define UVC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/utf8vc_pkg.sv
// Types, constants and error codes of the UTF-8 validator.
package utf8vc_pkg;

  localparam int unsigned CntW = 11;
  localparam int unsigned CpW  = 21;

  localparam logic [CntW-1:0] CNT_MAX = '1;

  localparam logic [CntW-1:0] MIN_CHARS_RST = 11'd8;
  localparam logic [CntW-1:0] MAX_CHARS_RST = 11'd128;
  localparam logic [CntW-1:0] BYTE_CAP_RST  = 11'd513;

  // Configuration register indexes.
  localparam logic [1:0] REG_MIN_CHARS = 2'd0;
  localparam logic [1:0] REG_MAX_CHARS = 2'd1;
  localparam logic [1:0] REG_BYTE_CAP  = 2'd2;

  // Error codes.
  localparam logic [3:0] ERR_NONE      = 4'd0;
  localparam logic [3:0] ERR_CONTROL   = 4'd1;
  localparam logic [3:0] ERR_LEAD      = 4'd2;
  localparam logic [3:0] ERR_CONT      = 4'd3;
  localparam logic [3:0] ERR_OVERLONG  = 4'd4;
  localparam logic [3:0] ERR_RANGE     = 4'd5;
  localparam logic [3:0] ERR_TRUNCATED = 4'd6;
  localparam logic [3:0] ERR_TOO_LONG  = 4'd7;
  localparam logic [3:0] ERR_COUNT     = 4'd8;

  // Byte and code point limits.
  localparam logic [7:0]     CTRL_LIMIT  = 8'h20;
  localparam logic [7:0]     DEL_BYTE    = 8'h7f;
  localparam logic [7:0]     ASCII_LIMIT = 8'h80;
  localparam logic [7:0]     LEAD2_LO    = 8'hc2;
  localparam logic [7:0]     LEAD2_HI    = 8'hdf;
  localparam logic [7:0]     LEAD3_LO    = 8'he0;
  localparam logic [7:0]     LEAD3_HI    = 8'hef;
  localparam logic [7:0]     LEAD4_LO    = 8'hf0;
  localparam logic [7:0]     LEAD4_HI    = 8'hf4;
  localparam logic [CpW-1:0] CP_MIN2     = 21'h80;
  localparam logic [CpW-1:0] CP_MIN3     = 21'h800;
  localparam logic [CpW-1:0] CP_MIN4     = 21'h10000;
  localparam logic [CpW-1:0] CP_MAX      = 21'h10ffff;
  localparam logic [CpW-1:0] SURR_LO     = 21'hd800;
  localparam logic [CpW-1:0] SURR_HI     = 21'hdfff;

  typedef struct packed {
    logic [1:0]      bytes_pending;
    logic [1:0]      sequence_length;
    logic [CpW-1:0]  code_point_acc;
    logic [CntW-1:0] point_count;
    logic [CntW-1:0] byte_count;
    logic [3:0]      first_error;
  } state_t;

  typedef struct packed {
    logic [CntW-1:0] min_chars;
    logic [CntW-1:0] max_chars;
    logic [CntW-1:0] byte_capacity;
  } cfg_t;

  typedef struct packed {
    logic            valid_res;
    logic [3:0]      error_code;
    logic [CntW-1:0] char_count;
  } result_t;

endpackage

### hdl/utf8vc_step.sv
// Per-byte decode: validates one byte against the running state and forms the verdict.
module utf8vc_step (
  input  utf8vc_pkg::state_t  state_i,
  input  utf8vc_pkg::cfg_t    cfg_i,
  input  logic [7:0]          data_byte_i,
  input  logic                is_last_i,
  output utf8vc_pkg::state_t  state_o,
  output utf8vc_pkg::result_t result_o
);
  import utf8vc_pkg::*;

  state_t         s;
  logic [CpW-1:0] cp;
  logic [3:0]     err;

  always_comb begin
    s  = state_i;
    cp = {state_i.code_point_acc[CpW-7:0], data_byte_i[5:0]};

    if (s.byte_count != CNT_MAX) begin
      s.byte_count = s.byte_count + 1'b1;
    end

    if (state_i.first_error == ERR_NONE) begin
      if (state_i.bytes_pending != 2'd0) begin
        if (data_byte_i[7:6] != 2'b10) begin
          s.first_error = ERR_CONT;
        end else begin
          s.code_point_acc = cp;
          s.bytes_pending  = state_i.bytes_pending - 2'd1;
          if (state_i.bytes_pending == 2'd1) begin
            // Sequence complete: check for overlong forms, then the legal range.
            if ((state_i.sequence_length == 2'd1 && cp < CP_MIN2) ||
                (state_i.sequence_length == 2'd2 && cp < CP_MIN3) ||
                (state_i.sequence_length == 2'd3 && cp < CP_MIN4)) begin
              s.first_error = ERR_OVERLONG;
            end else if (cp > CP_MAX || (cp >= SURR_LO && cp <= SURR_HI)) begin
              s.first_error = ERR_RANGE;
            end else if (s.point_count != CNT_MAX) begin
              s.point_count = s.point_count + 1'b1;
            end
            s.sequence_length = 2'd0;
            s.code_point_acc  = '0;
          end
        end
      end else if (data_byte_i < CTRL_LIMIT || data_byte_i == DEL_BYTE) begin
        s.first_error = ERR_CONTROL;
      end else if (data_byte_i < ASCII_LIMIT) begin
        if (s.point_count != CNT_MAX) begin
          s.point_count = s.point_count + 1'b1;
        end
      end else if (data_byte_i >= LEAD2_LO && data_byte_i <= LEAD2_HI) begin
        s.sequence_length = 2'd1;
        s.bytes_pending   = 2'd1;
        s.code_point_acc  = {{(CpW-5){1'b0}}, data_byte_i[4:0]};
      end else if (data_byte_i >= LEAD3_LO && data_byte_i <= LEAD3_HI) begin
        s.sequence_length = 2'd2;
        s.bytes_pending   = 2'd2;
        s.code_point_acc  = {{(CpW-4){1'b0}}, data_byte_i[3:0]};
      end else if (data_byte_i >= LEAD4_LO && data_byte_i <= LEAD4_HI) begin
        s.sequence_length = 2'd3;
        s.bytes_pending   = 2'd3;
        s.code_point_acc  = {{(CpW-3){1'b0}}, data_byte_i[2:0]};
      end else begin
        s.first_error = ERR_LEAD;
      end
    end

    if (s.first_error == ERR_NONE && s.bytes_pending != 2'd0) begin
      err = ERR_TRUNCATED;
    end else begin
      err = s.first_error;
    end

    // Length overflow outranks every encoding error.
    if (s.byte_count >= cfg_i.byte_capacity) begin
      err = ERR_TOO_LONG;
    end else if (err == ERR_NONE &&
                 (s.point_count < cfg_i.min_chars || s.point_count > cfg_i.max_chars)) begin
      err = ERR_COUNT;
    end

    result_o.valid_res  = (err == ERR_NONE);
    result_o.error_code = err;
    result_o.char_count = s.point_count;

    state_o = is_last_i ? '0 : s;
  end

endmodule

### hdl/utf8_validate_and_count_core.sv
// A string's result is presented from the result register once its final byte has left the input register.
// Throughput: one byte per cycle; the input register and the result register
// decouple the channels, and only a final byte waiting on an untaken result stalls.
// Reset (synchronous, rst_n low) clears the string state and loads the limits
// to min_chars 8, max_chars 128 and byte_capacity 513.
`include "utf8_validate_and_count_core_defines.svh"

module utf8_validate_and_count_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_data_byte,
  input  logic                        in_is_last,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_valid_res,
  output logic [3:0]                  out_error_code,
  output logic [utf8vc_pkg::CntW-1:0] out_char_count,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [utf8vc_pkg::CntW-1:0] cfg_wdata
);
  import utf8vc_pkg::*;

  cfg_t    cfg_r;
  state_t  state_r;
  state_t  state_nxt;
  result_t result_nxt;
  result_t result_r;
  logic    out_valid_r;
  logic    s1_valid_r;
  logic    s1_last_r;
  logic [7:0] s1_byte_r;
  logic    s1_adv;

  utf8vc_step u_step (
    .state_i     (state_r),
    .cfg_i       (cfg_r),
    .data_byte_i (s1_byte_r),
    .is_last_i   (s1_last_r),
    .state_o     (state_nxt),
    .result_o    (result_nxt)
  );

  // A non-final byte never needs the result register, so it always moves on.
  assign s1_adv   = s1_valid_r && (!s1_last_r || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_chars     <= MIN_CHARS_RST;
      cfg_r.max_chars     <= MAX_CHARS_RST;
      cfg_r.byte_capacity <= BYTE_CAP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_CHARS: cfg_r.min_chars     <= cfg_wdata;
        REG_MAX_CHARS: cfg_r.max_chars     <= cfg_wdata;
        REG_BYTE_CAP:  cfg_r.byte_capacity <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end

      if (s1_adv) begin
        state_r <= state_nxt;
      end

      if (s1_adv && s1_last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_is_last;
    end
    if (s1_adv && s1_last_r) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_valid_res  = result_r.valid_res;
  assign out_error_code = result_r.error_code;
  assign out_char_count = result_r.char_count;

  `UVC_ASSERT_SAME(a_verdict_matches_code, out_valid_r,
    result_r.valid_res == (result_r.error_code == ERR_NONE),
    "verdict disagrees with error code")
  `UVC_ASSERT_NEXT(a_state_clears_after_last, s1_adv && s1_last_r, state_r == '0,
    "string state not cleared after final byte")
  `UVC_ASSERT_NEXT(a_error_sticky,
    s1_adv && !s1_last_r && state_r.first_error != ERR_NONE,
    state_r.first_error == $past(state_r.first_error),
    "first error changed before end of string")
  `UVC_ASSERT_NEXT(a_final_byte_held,
    s1_valid_r && s1_last_r && out_valid_r && !out_ready,
    s1_valid_r && s1_last_r,
    "final byte dropped while result register was full")

endmodule
